FILE: src/trb_pkg.sv
// ----------------------------------------------------------------------------
// trb_pkg
// Shared widths, constants and types for the two-pass resonant band-pass
// filter: state format, coefficient format, configuration record and the
// request/response records of the shared multiplier and the sequencer status.
// ----------------------------------------------------------------------------
package trb_pkg;

    // Sample and state formats
    localparam int SAMPLE_BITS = 24;
    localparam int STATE_BITS  = 48;
    localparam int FRAC_BITS   = 8;
    localparam int OUT_W       = 32;

    // Coefficient operand: signed, wide enough for Q2.30 words and Q1.16 ratios
    localparam int COEF_W     = 33;
    localparam int COEF_MAG_W = 32;

    // Multiplier split: the state magnitude is multiplied in two halves
    localparam int LO_W   = (STATE_BITS + 1) / 2;
    localparam int HI_W   = STATE_BITS - LO_W;
    localparam int PP_W   = LO_W + COEF_MAG_W;
    localparam int PROD_W = STATE_BITS + COEF_MAG_W;

    // Product scaling
    localparam int SH_Q30 = 30;
    localparam int SH_Q16 = 16;

    // Saturation limits of a product magnitude
    localparam logic [PROD_W-1:0] LIM_POS =
        {{(PROD_W - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
    localparam logic [PROD_W-1:0] LIM_NEG =
        {{(PROD_W - STATE_BITS){1'b0}}, 1'b1, {(STATE_BITS - 1){1'b0}}};

    // Output saturation limits
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    // Coefficient constants
    localparam logic [30:0] FREQ_LIMIT = 31'd1405523545;
    localparam logic signed [COEF_W-1:0] CASCADE_GAIN = 33'sd1342177280;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PASS_MODE    = 3'd0,
        REG_COEF_FREQ    = 3'd1,
        REG_COEF_DECAY_B = 3'd2,
        REG_COEF_GAIN_B  = 3'd3,
        REG_COEF_DECAY_A = 3'd4,
        REG_COEF_GAIN_A  = 3'd5,
        REG_MIX_RATIO    = 3'd6
    } trb_reg_idx_t;

    typedef struct packed {
        logic               pass_mode;
        logic [30:0]        coef_freq;
        logic signed [31:0] coef_decay_b;
        logic signed [31:0] coef_gain_b;
        logic signed [31:0] coef_decay_a;
        logic signed [31:0] coef_gain_a;
        logic [16:0]        mix_ratio;
    } trb_cfg_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic                         start;
        logic                         sh16;
        logic signed [STATE_BITS-1:0] operand;
        logic signed [COEF_W-1:0]     coef;
    } trb_mul_req_t;

    // Response of the shared multiplier
    typedef struct packed {
        logic                         done;
        logic signed [STATE_BITS-1:0] result;
    } trb_mul_rsp_t;

    // Sequencer status towards the top level
    typedef struct packed {
        logic idle;
        logic res_valid;
    } trb_core_sts_t;

endpackage

FILE: src/two_pass_resonant_bandpass.sv
// ----------------------------------------------------------------------------
// two_pass_resonant_bandpass
// Two-pole resonator band-pass filter, single pass or two cascaded passes
// with a weighted output mix, on one shared multiplier.
//
//   channel  ports                          direction  width
//   s_       s_valid s_ready s_sample_in    in         SAMPLE_BITS
//   m_       m_valid m_ready m_sample_out   out        32
//   cfg_     cfg_wen cfg_addr cfg_wdata     in         3 / 32
//
// Each product passes through the shared multiplier as a half-width multiply
// twice, an add and a scale. A single-pass sample needs 4 products, a two-pass
// sample 10. The next request is taken once the sequencer has handed its
// result to the output register and returned to idle.
// Reset clears configuration and filter state; no clearing pass is needed.
// A new request is taken while the previous result still waits in the
// output register; the sequencer stalls at its end while that register is full.
// ----------------------------------------------------------------------------
module two_pass_resonant_bandpass import trb_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [OUT_W-1:0]       m_sample_out
);

    trb_cfg_t             cfg_reg, cfg_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]     m_data_reg, m_data_next;

    trb_core_sts_t        core_sts;
    logic signed [OUT_W-1:0] core_data;
    logic                 res_ready;

    // Register writes; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wen) begin
            case (cfg_addr)
                REG_PASS_MODE:    cfg_next.pass_mode    = cfg_wdata[0];
                REG_COEF_FREQ:    cfg_next.coef_freq    = cfg_wdata[30:0];
                REG_COEF_DECAY_B: cfg_next.coef_decay_b = signed'(cfg_wdata);
                REG_COEF_GAIN_B:  cfg_next.coef_gain_b  = signed'(cfg_wdata);
                REG_COEF_DECAY_A: cfg_next.coef_decay_a = signed'(cfg_wdata);
                REG_COEF_GAIN_A:  cfg_next.coef_gain_a  = signed'(cfg_wdata);
                REG_MIX_RATIO:    cfg_next.mix_ratio    = cfg_wdata[16:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    trb_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .start     (s_valid && core_sts.idle),
        .sample    (s_sample_in),
        .res_ready (res_ready),
        .sts       (core_sts),
        .res_data  (core_data)
    );

    // Output register: load when empty or being drained, hold otherwise
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (core_sts.res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = core_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            cfg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready      = core_sts.idle;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = signed'(m_data_reg);

endmodule

FILE: src/trb_mul.sv
// ----------------------------------------------------------------------------
// trb_mul
// Shared multi-cycle multiplier: state value times coefficient, scaled by
// 2^-30 or 2^-16 with rounding towards minus infinity, saturated to the
// signed state range. One half of the operand is multiplied per cycle.
// ----------------------------------------------------------------------------
module trb_mul import trb_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  trb_mul_req_t req,
    output trb_mul_rsp_t rsp
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_LO,
        M_HI,
        M_ADD,
        M_FIN
    } mul_state_t;

    mul_state_t              state_reg, state_next;
    logic                    done_reg, done_next;
    logic                    neg_reg, neg_next;
    logic                    sh16_reg, sh16_next;
    logic [STATE_BITS-1:0]   ua_reg, ua_next;
    logic [COEF_MAG_W-1:0]   uc_reg, uc_next;
    logic [PP_W-1:0]         prod_reg, prod_next;
    logic [PROD_W-1:0]       acc_reg, acc_next;
    logic [STATE_BITS-1:0]   res_reg, res_next;

    logic [PP_W-1:0]         mul_a;
    logic [PP_W-1:0]         mul_b;
    logic [STATE_BITS-1:0]   op_neg;
    logic [COEF_W-1:0]       coef_neg;
    logic [PROD_W-1:0]       shifted;
    logic                    rem_nz;
    logic [PROD_W-1:0]       rounded;
    logic [PROD_W-1:0]       lim;
    logic [STATE_BITS-1:0]   mag;

    // Shared multiplier: low half first, then high half
    assign mul_a = (state_reg == M_LO) ? PP_W'(ua_reg[LO_W-1:0])
                                       : PP_W'(ua_reg[STATE_BITS-1:LO_W]);
    assign mul_b = PP_W'(uc_reg);

    assign op_neg   = STATE_BITS'(-req.operand);
    assign coef_neg = -req.coef;

    // Scale, round towards minus infinity and clamp the magnitude
    always_comb begin
        if (sh16_reg) begin
            shifted = acc_reg >> SH_Q16;
            rem_nz  = |acc_reg[SH_Q16-1:0];
        end else begin
            shifted = acc_reg >> SH_Q30;
            rem_nz  = |acc_reg[SH_Q30-1:0];
        end
        rounded = shifted + PROD_W'(neg_reg && rem_nz);
        lim     = neg_reg ? LIM_NEG : LIM_POS;
        if (rounded > lim) begin
            mag = lim[STATE_BITS-1:0];
        end else begin
            mag = rounded[STATE_BITS-1:0];
        end
    end

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        sh16_next  = sh16_reg;
        ua_next    = ua_reg;
        uc_next    = uc_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        case (state_reg)
            M_IDLE: begin
                if (req.start) begin
                    neg_next   = req.operand[STATE_BITS-1] ^ req.coef[COEF_W-1];
                    sh16_next  = req.sh16;
                    ua_next    = req.operand[STATE_BITS-1] ? op_neg : req.operand;
                    uc_next    = req.coef[COEF_W-1] ? coef_neg[COEF_MAG_W-1:0]
                                                    : req.coef[COEF_MAG_W-1:0];
                    state_next = M_LO;
                end
            end
            M_LO: begin
                prod_next  = mul_a * mul_b;
                state_next = M_HI;
            end
            M_HI: begin
                acc_next   = PROD_W'(prod_reg);
                prod_next  = mul_a * mul_b;
                state_next = M_ADD;
            end
            M_ADD: begin
                acc_next   = acc_reg + (PROD_W'(prod_reg) << LO_W);
                state_next = M_FIN;
            end
            M_FIN: begin
                res_next   = neg_reg ? STATE_BITS'(-mag) : mag;
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default: begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        neg_reg  <= neg_next;
        sh16_reg <= sh16_next;
        ua_reg   <= ua_next;
        uc_reg   <= uc_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = signed'(res_reg);

endmodule

FILE: src/trb_core.sv
// ----------------------------------------------------------------------------
// trb_core
// Sequencer of the resonator passes: holds the filter state, steps through
// the products of one sample on the shared multiplier and folds each product
// into the state with saturating add and subtract.
// ----------------------------------------------------------------------------
module trb_core import trb_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  trb_cfg_t                      cfg,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          res_ready,
    output trb_core_sts_t                 sts,
    output logic signed [OUT_W-1:0]       res_data
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_ISSUE,
        C_WAIT,
        C_DONE
    } core_state_t;

    // One entry per product of the sample
    typedef enum logic [3:0] {
        ST_A1, ST_A2, ST_A3, ST_A4,
        ST_B1, ST_B2, ST_B3, ST_B4,
        ST_X1, ST_X2
    } step_t;

    typedef logic signed [STATE_BITS-1:0] state_word_t;

    core_state_t state_reg, state_next;
    step_t       step_reg, step_next;
    state_word_t s0a_reg, s0a_next;
    state_word_t s1a_reg, s1a_next;
    state_word_t s0b_reg, s0b_next;
    state_word_t s1b_reg, s1b_next;
    state_word_t x_reg, x_next;
    state_word_t t_reg, t_next;
    state_word_t y_reg, y_next;

    trb_mul_req_t mul_req;
    trb_mul_rsp_t mul_rsp;

    logic signed [SAMPLE_BITS+FRAC_BITS-1:0] x_scaled;
    logic [30:0]                              freq_use;
    logic signed [COEF_W-1:0]                 freq_c;
    state_word_t                              m;
    state_word_t                              ip;
    logic [STATE_BITS-OUT_W:0]                ip_top;

    // Saturating add or subtract in the state range
    function automatic state_word_t sat_addsub(input state_word_t a,
                                               input state_word_t b,
                                               input logic sub);
        logic [STATE_BITS:0] s;
        state_word_t         r;
        if (sub) begin
            s = {a[STATE_BITS-1], a} - {b[STATE_BITS-1], b};
        end else begin
            s = {a[STATE_BITS-1], a} + {b[STATE_BITS-1], b};
        end
        if (s[STATE_BITS] != s[STATE_BITS-1]) begin
            r = s[STATE_BITS] ? {1'b1, {(STATE_BITS - 1){1'b0}}}
                              : {1'b0, {(STATE_BITS - 1){1'b1}}};
        end else begin
            r = s[STATE_BITS-1:0];
        end
        return r;
    endfunction

    trb_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // Scale the sample into state format and limit the frequency word
    assign x_scaled = {sample, {FRAC_BITS{1'b0}}};
    assign freq_use = (cfg.coef_freq > FREQ_LIMIT) ? FREQ_LIMIT : cfg.coef_freq;
    assign freq_c   = signed'(COEF_W'(freq_use));
    assign m        = mul_rsp.result;

    // Select the operands of the current product
    always_comb begin
        mul_req.start   = (state_reg == C_ISSUE);
        mul_req.sh16    = 1'b0;
        mul_req.operand = t_reg;
        mul_req.coef    = freq_c;
        case (step_reg)
            ST_A1: begin
                mul_req.operand = s1a_reg;
                mul_req.coef    = COEF_W'(cfg.coef_decay_a);
            end
            ST_A2: begin
                mul_req.operand = s0a_reg;
            end
            ST_A3: begin
                mul_req.operand = x_reg;
                mul_req.coef    = COEF_W'(cfg.coef_gain_a);
            end
            ST_B1: begin
                mul_req.operand = s1b_reg;
                mul_req.coef    = COEF_W'(cfg.coef_decay_b);
            end
            ST_B2: begin
                mul_req.operand = s0b_reg;
            end
            ST_B3: begin
                mul_req.operand = cfg.pass_mode ? s1a_reg : x_reg;
                mul_req.coef    = COEF_W'(cfg.coef_gain_b);
            end
            ST_X1: begin
                mul_req.operand = s1a_reg;
                mul_req.coef    = signed'(COEF_W'(cfg.mix_ratio));
                mul_req.sh16    = 1'b1;
            end
            ST_X2: begin
                mul_req.operand = s1b_reg;
                mul_req.coef    = CASCADE_GAIN;
            end
            default: begin
                mul_req.operand = t_reg;
            end
        endcase
    end

    // Sequencer: issue a product, fold it in, advance
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s0a_next   = s0a_reg;
        s1a_next   = s1a_reg;
        s0b_next   = s0b_reg;
        s1b_next   = s1b_reg;
        x_next     = x_reg;
        t_next     = t_reg;
        y_next     = y_reg;
        case (state_reg)
            C_IDLE: begin
                if (start) begin
                    x_next     = STATE_BITS'(x_scaled);
                    step_next  = cfg.pass_mode ? ST_A1 : ST_B1;
                    state_next = C_ISSUE;
                end
            end
            C_ISSUE: begin
                state_next = C_WAIT;
            end
            C_WAIT: begin
                if (mul_rsp.done) begin
                    state_next = C_ISSUE;
                    case (step_reg)
                        ST_A1: begin
                            t_next    = m;
                            step_next = ST_A2;
                        end
                        ST_A2: begin
                            t_next    = sat_addsub(t_reg, m, 1'b0);
                            step_next = ST_A3;
                        end
                        ST_A3: begin
                            t_next    = sat_addsub(t_reg, m, 1'b1);
                            step_next = ST_A4;
                        end
                        ST_A4: begin
                            s0a_next  = sat_addsub(s0a_reg, m, 1'b1);
                            s1a_next  = t_reg;
                            step_next = ST_B1;
                        end
                        ST_B1: begin
                            t_next    = m;
                            step_next = ST_B2;
                        end
                        ST_B2: begin
                            t_next    = sat_addsub(t_reg, m, 1'b0);
                            step_next = ST_B3;
                        end
                        ST_B3: begin
                            t_next    = sat_addsub(t_reg, m, 1'b1);
                            step_next = ST_B4;
                        end
                        ST_B4: begin
                            s0b_next = sat_addsub(s0b_reg, m, 1'b1);
                            s1b_next = t_reg;
                            if (cfg.pass_mode) begin
                                step_next = ST_X1;
                            end else begin
                                y_next     = t_reg;
                                state_next = C_DONE;
                            end
                        end
                        ST_X1: begin
                            y_next    = m;
                            step_next = ST_X2;
                        end
                        ST_X2: begin
                            y_next     = sat_addsub(y_reg, m, 1'b1);
                            state_next = C_DONE;
                        end
                        default: begin
                            state_next = C_DONE;
                        end
                    endcase
                end
            end
            C_DONE: begin
                if (res_ready) begin
                    state_next = C_IDLE;
                end
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        t_reg <= t_next;
        y_reg <= y_next;
        if (!aresetn) begin
            state_reg <= C_IDLE;
            step_reg  <= ST_A1;
            s0a_reg   <= '0;
            s1a_reg   <= '0;
            s0b_reg   <= '0;
            s1b_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            s0a_reg   <= s0a_next;
            s1a_reg   <= s1a_next;
            s0b_reg   <= s0b_next;
            s1b_reg   <= s1b_next;
        end
    end

    // Integer part of the result, saturated to the output width
    assign ip     = y_reg >>> FRAC_BITS;
    assign ip_top = ip[STATE_BITS-1:OUT_W-1];

    always_comb begin
        if ((&ip_top) || !(|ip_top)) begin
            res_data = signed'(ip[OUT_W-1:0]);
        end else if (ip[STATE_BITS-1]) begin
            res_data = signed'(OUT_MIN);
        end else begin
            res_data = signed'(OUT_MAX);
        end
    end

    assign sts.idle      = (state_reg == C_IDLE);
    assign sts.res_valid = (state_reg == C_DONE);

endmodule
